// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the page allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pcpa_pkg.sv =====
// Shared types and constants of the per-CPU page allocator
package pcpa_pkg;

	localparam int NUM_CPUS   = 8;
	localparam int CPU_W      = 3;
	localparam int MAX_PAGES  = 32768;
	localparam int PAGE_W     = $clog2(MAX_PAGES);
	localparam int PAGE_SHIFT = 12;
	localparam int ADDR_W     = 40;
	localparam int PFN_W      = ADDR_W - PAGE_SHIFT;
	localparam int LINK_W     = PAGE_W + 1;
	localparam int DATA_W     = 48;

	// request kinds
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_OOM  = 2'd1;
	localparam logic [1:0] STATUS_BAD  = 2'd2;

	// configuration register indexes
	localparam logic REG_START = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	localparam logic [ADDR_W-1:0] START_RST = 40'h00_8000_0000;
	localparam logic [ADDR_W-1:0] LIMIT_RST = 40'h00_8800_0000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_t;

endpackage

// ===== rtl/core/pcpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data
module pcpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/per_cpu_page_allocator.sv =====
// Top level of the per-CPU LIFO free-list page allocator
//
// Requests come in on the s_* stream: s_tuser[0] is the kind (0 allocate,
// 1 free), s_tdata holds the CPU index and, for a free, the page address.
// Every request gives exactly one result item on the m_* stream: m_tuser is
// the status (ok, out of memory, bad free address), m_tdata the allocated
// address and the list that supplied or received the page.
// Each CPU list is a head register plus a next-link table in one
// 32768-entry synchronous RAM, indexed by page offset from the region start.
// Steps: a free is accepted, then checked and pushed; an allocate is
// accepted, then picks a list and reads the link RAM, then updates the
// head. The allocate needs its extra step because the RAM read of the
// next link must finish before the head can move. One request is in work at a time.
// The result sits in an output register; while the receiver stalls, the
// next request is still accepted and worked up to its result, then waits.
// Reset empties every list at once (head valid bits cleared) and loads the
// region registers with their defaults; the link RAM needs no clearing.
// region_start and region_limit are written through cfg_we/cfg_addr/
// cfg_wdata while no request is in work; the user must keep to this, the block does not enforce it.
`include "assert_macros.svh"

module per_cpu_page_allocator (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes
	input  logic                                cfg_we,
	input  logic                                cfg_addr,
	input  logic [pcpa_pkg::ADDR_W-1:0]         cfg_wdata,
	// requests
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [pcpa_pkg::DATA_W-1:0]         s_tdata,  // cpu_id[2:0], page_addr[42:3]
	input  logic                                s_tuser,  // req_type[0]
	// results
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [pcpa_pkg::DATA_W-1:0]         m_tdata,  // alloc_addr[39:0], served_by[42:40]
	output logic [1:0]                          m_tuser   // status[1:0]
);

	localparam int AW = pcpa_pkg::ADDR_W;
	localparam int PW = pcpa_pkg::PAGE_W;
	localparam int CW = pcpa_pkg::CPU_W;
	localparam int FW = pcpa_pkg::PFN_W;
	localparam int SH = pcpa_pkg::PAGE_SHIFT;

	pcpa_pkg::state_t state_q, state_d;

	logic [AW-1:0] start_q, limit_q;
	logic          req_q;
	logic [CW-1:0] cpu_q;
	logic [AW-1:0] addr_q;
	logic [CW-1:0] sel_q;

	logic [PW-1:0] head_q     [pcpa_pkg::NUM_CPUS];
	logic          head_vld_q [pcpa_pkg::NUM_CPUS];

	logic          ovld_q;
	logic [1:0]    ostat_q;
	logic [AW-1:0] oaddr_q;
	logic [CW-1:0] oserv_q;

	logic          out_free;
	logic          aligned, in_range, idx_ok, cpu_ok, free_ok;
	logic [FW-1:0] pfn_diff;
	logic          any_vld, own_vld, got;
	logic [CW-1:0] first_idx, pick;
	logic [FW-1:0] alloc_pfn;

	logic                        ram_we, ram_re;
	logic [pcpa_pkg::LINK_W-1:0] ram_rdata;

	logic          load_out, head_push, head_pop, sel_load;
	logic [1:0]    ostat_d;
	logic [AW-1:0] oaddr_d;
	logic [CW-1:0] oserv_d;

	assign out_free = !ovld_q || m_tready;

	// free address check
	assign aligned  = (addr_q[SH-1:0] == '0);
	assign in_range = (addr_q >= start_q) && (addr_q < limit_q);
	assign cpu_ok   = (32'(cpu_q) < pcpa_pkg::NUM_CPUS);
	assign pfn_diff = addr_q[AW-1:SH] - start_q[AW-1:SH];
	assign idx_ok   = (pfn_diff[FW-1:PW] == '0);
	assign free_ok  = aligned && in_range && cpu_ok && idx_ok;

	// list choice: own list first, else lowest non-empty list
	always_comb begin
		any_vld   = 1'b0;
		first_idx = '0;
		for (int i = 0; i < pcpa_pkg::NUM_CPUS; i++) begin
			if (head_vld_q[i] && !any_vld) begin
				any_vld   = 1'b1;
				first_idx = CW'(i);
			end
		end
	end

	assign own_vld = cpu_ok && head_vld_q[cpu_q];
	assign pick    = own_vld ? cpu_q : first_idx;
	assign got     = any_vld;

	assign alloc_pfn = start_q[AW-1:SH] + FW'(head_q[sel_q]);

	// next-link table: {link valid, next page}
	pcpa_ram #(
		.WIDTH (pcpa_pkg::LINK_W),
		.DEPTH (pcpa_pkg::MAX_PAGES)
	) u_links (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pfn_diff[PW-1:0]),
		.wdata ({head_vld_q[cpu_q], head_q[cpu_q]}),
		.re    (ram_re),
		.raddr (head_q[pick]),
		.rdata (ram_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		load_out  = 1'b0;
		head_push = 1'b0;
		head_pop  = 1'b0;
		sel_load  = 1'b0;
		ostat_d   = pcpa_pkg::STATUS_OK;
		oaddr_d   = '0;
		oserv_d   = '0;
		case (state_q)
			pcpa_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = pcpa_pkg::ST_EXEC;
				end
			end
			pcpa_pkg::ST_EXEC: begin
				if (req_q == pcpa_pkg::REQ_FREE) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = pcpa_pkg::ST_IDLE;
						if (free_ok) begin
							ram_we    = 1'b1;
							head_push = 1'b1;
							oserv_d   = cpu_q;
						end else begin
							ostat_d = pcpa_pkg::STATUS_BAD;
						end
					end
				end else if (got) begin
					ram_re   = 1'b1;
					sel_load = 1'b1;
					state_d  = pcpa_pkg::ST_READ;
				end else if (out_free) begin
					load_out = 1'b1;
					ostat_d  = pcpa_pkg::STATUS_OOM;
					state_d  = pcpa_pkg::ST_IDLE;
				end
			end
			pcpa_pkg::ST_READ: begin
				if (out_free) begin
					load_out = 1'b1;
					head_pop = 1'b1;
					oaddr_d  = {alloc_pfn, {SH{1'b0}}};
					oserv_d  = sel_q;
					state_d  = pcpa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pcpa_pkg::ST_IDLE;
			end
		endcase
	end

	// region registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= pcpa_pkg::START_RST;
			limit_q <= pcpa_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				pcpa_pkg::REG_START: start_q <= cfg_wdata;
				pcpa_pkg::REG_LIMIT: limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// captured request and chosen list
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q  <= s_tuser;
			cpu_q  <= s_tdata[CW-1:0];
			addr_q <= s_tdata[CW+AW-1:CW];
		end
		if (sel_load) begin
			sel_q <= pick;
		end
	end

	// list heads: valid bits cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pcpa_pkg::NUM_CPUS; i++) begin
				head_vld_q[i] <= 1'b0;
			end
		end else if (head_push) begin
			head_vld_q[cpu_q] <= 1'b1;
		end else if (head_pop) begin
			head_vld_q[sel_q] <= ram_rdata[PW];
		end
	end

	always_ff @(posedge clk) begin
		if (head_push) begin
			head_q[cpu_q] <= pfn_diff[PW-1:0];
		end else if (head_pop) begin
			head_q[sel_q] <= ram_rdata[PW-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (load_out) begin
			ovld_q <= 1'b1;
		end else if (m_tready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			ostat_q <= ostat_d;
			oaddr_q <= oaddr_d;
			oserv_q <= oserv_d;
		end
	end

	assign m_tvalid = ovld_q;
	assign m_tuser  = ostat_q;
	assign m_tdata  = {{(pcpa_pkg::DATA_W-AW-CW){1'b0}}, oserv_q, oaddr_q};

	// a pop only completes from a list that held a page
	`ASSERT_IMPL(a_pop_from_valid, clk, arst_n, state_q == pcpa_pkg::ST_READ,
		head_vld_q[sel_q], "pop from an empty list")

	// a good free leaves the requester's list non-empty
	`ASSERT_NEXT(a_push_sets_head, clk, arst_n, head_push, head_vld_q[cpu_q],
		"push did not mark head valid")

	// results carry only defined status codes
	`ASSERT_IMPL(a_status_code, clk, arst_n, m_tvalid,
		(m_tuser == pcpa_pkg::STATUS_OK) || (m_tuser == pcpa_pkg::STATUS_OOM)
			|| (m_tuser == pcpa_pkg::STATUS_BAD),
		"undefined status code")

endmodule
